@@ rtl/core/stramp_pkg.sv @@
// Shared types, widths and codes for the trapezoidal step-rate generator.
package stramp_pkg;

  localparam int RATE_W   = 17;
  localparam int ACC_W    = 20;
  localparam int CNT_W    = 32;
  localparam int IVL_W    = 20;
  localparam int MUL_AW   = 32;
  localparam int MUL_BW   = 20;
  localparam int MUL_PW   = MUL_AW + MUL_BW;
  localparam int SQ_W     = 54;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int DIV_NW   = 34;
  localparam int DIV_DW   = ACC_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int TIMER_CLOCK_HZ_DEF = 1000000;

  localparam logic [IVL_W-1:0] IVL_MAX = {IVL_W{1'b1}};

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;
  localparam logic [1:0] MODE_SETPOS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_ACCEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_ACCEL  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START_INIT, OP_MUL_CRUISE, OP_START_DP,
    OP_MUL_CUR, OP_STOP_APPLY, OP_HALT, OP_SETPOS, OP_TICK_BASE,
    OP_MUL_MIN, OP_MUL_ACNT, OP_SUM, OP_ACCEL_APPLY, OP_CRUISE_APPLY,
    OP_MUL_ENTRY, OP_MUL_AN, OP_DIFF, OP_DECEL_MIN, OP_DECEL_APPLY,
    OP_SET_IVL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sqrt_start;
    logic   div_start;
    logic   div_ivl;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    phase_t     phase;
    logic       steps_nz;
    logic       stop_ramp;
    logic       tick_end;
    logic       red_ge;
    logic       out_free;
    logic       div_done;
    logic       sqrt_done;
  } dp_stat_t;

endpackage

@@ rtl/core/stepper_trapezoid_ramp_unit.sv @@
// Top level of the trapezoidal step-rate generator for one stepper motor.
//
// Usage:
//   in_*  : command items. in_tuser = mode (tick, start, stop, set position),
//           in_tdata = move_steps (low word) and position_value (high word).
//   out_* : one result item per command item, in order.
//   cfg_* : register writes (min speed, speed limit, default accel, move max
//           speed, move accel), always ready; write only while idle.
// Results are registered once the controller finishes an item; the next item
// can be taken in the cycle after. Set position, ignored commands, idle ticks,
// halting stops and the final tick of a move need no arithmetic; a stop with
// ramp-down uses the v^2/2a divide; a start uses it and the TIMER_CLOCK_HZ/rate
// divide; cruise and decel-at-min-speed ticks use the rate divide; accel or decel
// ticks use the square root and the rate divide, both iterative units.
// The output register holds a finished result while a new item is taken, so
// a stalled receiver only blocks once a second result is ready.
// Reset (rst_n low, synchronous): motor idle, position and counts zero,
// registers at their documented defaults, output channel empty.
// A stalled result holds its data until out_tready.
module stepper_trapezoid_ramp_unit import stramp_pkg::*; #(
  parameter int TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [31:0] move_steps, [63:32] position_value
  input  logic [1:0]           in_tuser,   // [1:0] mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [0] step_pulse, [1] direction, [33:2] position, [53:34] interval_ticks,
  // [54] load_interval, [55] running, [56] start_accepted, [57] done_event,
  // [58] done_completed, [63:59] zero
  output logic [63:0]          out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t st;

  assign cfg_ready = 1'b1;

  stramp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .st(st), .cmd(cmd)
  );

  stramp_dp #(.TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_mode(in_tuser), .in_data(in_tdata),
    .cfg_we(cfg_valid & cfg_ready), .cfg_idx(cfg_index), .cfg_dat(cfg_data),
    .out_ready(out_tready), .out_valid(out_tvalid), .out_data(out_tdata)
  );
endmodule

@@ rtl/core/stramp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module stramp_div import stramp_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quot = q_r;
  assign done = done_r;
endmodule

@@ rtl/core/stramp_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module stramp_isqrt import stramp_pkg::*; #(
  parameter int RW = SQ_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   rad,
  output logic [RW/2-1:0] root,
  output logic            done
);
  localparam int TW   = RW / 2;
  localparam int REMW = TW + 2;
  localparam int CW   = $clog2(TW + 1);

  logic [RW-1:0]   x_r;
  logic [TW-1:0]   root_r;
  logic [REMW-1:0] rem_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [REMW+1:0] trial, sub, diff;
  logic            ge;

  assign trial = {rem_r, x_r[RW-1:RW-2]};
  assign sub   = {{(REMW - TW){1'b0}}, root_r, 2'b01};
  assign ge    = trial >= sub;
  assign diff  = trial - sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(TW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[RW-3:0], 2'b00};
      rem_r  <= ge ? diff[REMW-1:0] : trial[REMW-1:0];
      root_r <= {root_r[TW-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;
endmodule

@@ rtl/core/stramp_dp.sv @@
// Datapath: motion state, config registers, shared multiplier, root and divide units.
module stramp_dp import stramp_pkg::*; #(
  parameter int TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             st,
  input  logic [1:0]           in_mode,
  input  logic [63:0]          in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_dat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [63:0]          out_data
);
  localparam logic [DIV_NW-1:0] CLK_NUM = DIV_NW'(TIMER_CLOCK_HZ);

  // config
  logic [RATE_W-1:0] min_r, limit_r, mmax_r;
  logic [ACC_W-1:0]  dacc_r, macc_r;
  // motion state
  logic [CNT_W-1:0]  pos_r, remain_r, taken_r, ramp_cnt_r, dpoint_r;
  logic [RATE_W-1:0] cur_r, entry_r, cruise_r;
  logic [ACC_W-1:0]  accel_r;
  logic              fwd_r;
  phase_t            phase_r;
  // item and result flags
  logic [1:0]        mode_r;
  logic [CNT_W-1:0]  steps_r, newpos_r;
  logic              pulse_r, load_r, acc_ok_r, done_r, compl_r;
  logic [IVL_W-1:0]  ivl_r;
  // arithmetic
  logic [SQ_W-1:0]   acc_r;
  logic [MUL_PW-1:0] prod_r;
  logic              ovalid_r;
  logic [63:0]       odata_r;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic [SQ_W-1:0]   prod2;
  logic [CNT_W-1:0]  dec_n, mag;
  logic [RATE_W-1:0] clamp_lo, clamp_v, dec_t;
  logic [DIV_NW-1:0] div_num, div_q, dist_q;
  logic [DIV_DW-1:0] div_den;
  logic [ROOT_W-1:0] root;
  logic              div_done, sqrt_done, past_dp;

  assign prod2    = {1'b0, prod_r, 1'b0};
  assign dec_n    = (taken_r >= dpoint_r) ? taken_r - dpoint_r : '0;
  assign mag      = steps_r[CNT_W-1] ? (CNT_W'(0) - steps_r) : steps_r;
  assign clamp_lo = (mmax_r < min_r) ? min_r : mmax_r;
  assign clamp_v  = (clamp_lo > limit_r) ? limit_r : clamp_lo;
  assign past_dp  = taken_r >= dpoint_r;
  assign dist_q   = (accel_r == '0) ? '0 : div_q;
  assign dec_t    = (root < ROOT_W'(cur_r)) ? root[RATE_W-1:0] : cur_r;

  always_comb begin
    case (cmd.op)
      OP_MUL_CRUISE: begin mul_a = MUL_AW'(cruise_r); mul_b = MUL_BW'(cruise_r); end
      OP_MUL_CUR:    begin mul_a = MUL_AW'(cur_r);    mul_b = MUL_BW'(cur_r);    end
      OP_MUL_MIN:    begin mul_a = MUL_AW'(min_r);    mul_b = MUL_BW'(min_r);    end
      OP_MUL_ENTRY:  begin mul_a = MUL_AW'(entry_r);  mul_b = MUL_BW'(entry_r);  end
      OP_MUL_ACNT:   begin mul_a = ramp_cnt_r;        mul_b = accel_r;           end
      OP_MUL_AN:     begin mul_a = dec_n;             mul_b = accel_r;           end
      default:       begin mul_a = '0;                mul_b = '0;                end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign div_num = cmd.div_ivl ? CLK_NUM : acc_r[DIV_NW-1:0];
  assign div_den = cmd.div_ivl ? ((cur_r == '0) ? DIV_DW'(1) : DIV_DW'(cur_r))
                               : {accel_r, 1'b0};

  stramp_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(div_num), .den(div_den), .quot(div_q), .done(div_done)
  );

  stramp_isqrt #(.RW(SQ_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start),
    .rad(acc_r), .root(root), .done(sqrt_done)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= RATE_W'(100);
      limit_r <= RATE_W'(10000);
      dacc_r  <= ACC_W'(1000);
      mmax_r  <= RATE_W'(1000);
      macc_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_SPEED:   min_r   <= cfg_dat[RATE_W-1:0];
        CFG_SPEED_LIMIT: limit_r <= cfg_dat[RATE_W-1:0];
        CFG_DEF_ACCEL:   dacc_r  <= cfg_dat[ACC_W-1:0];
        CFG_MOVE_MAX:    mmax_r  <= cfg_dat[RATE_W-1:0];
        CFG_MOVE_ACCEL:  macc_r  <= cfg_dat[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  // motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; remain_r <= '0; taken_r <= '0; ramp_cnt_r <= '0; dpoint_r <= '0;
      cur_r <= '0; entry_r <= '0; cruise_r <= '0; accel_r <= '0;
      fwd_r <= 1'b0; phase_r <= PH_IDLE;
    end else begin
      case (cmd.op)
        OP_SETPOS: if (phase_r == PH_IDLE) pos_r <= newpos_r;
        OP_START_INIT: begin
          fwd_r      <= ~steps_r[CNT_W-1];
          remain_r   <= mag;
          taken_r    <= '0;
          cruise_r   <= clamp_v;
          accel_r    <= (macc_r != '0) ? macc_r : dacc_r;
          cur_r      <= min_r;
          ramp_cnt_r <= '0;
          phase_r    <= PH_ACCEL;
        end
        OP_START_DP: begin
          if ({dist_q, 1'b0} >= (DIV_NW + 1)'(remain_r)) dpoint_r <= remain_r >> 1;
          else dpoint_r <= remain_r - dist_q[CNT_W-1:0];
        end
        OP_STOP_APPLY: begin
          dpoint_r <= taken_r;
          remain_r <= (dist_q[DIV_NW-1:CNT_W] != '0) ? {CNT_W{1'b1}} : dist_q[CNT_W-1:0];
          entry_r  <= cur_r;
          phase_r  <= PH_DECEL;
        end
        OP_HALT: phase_r <= PH_IDLE;
        OP_TICK_BASE: begin
          pos_r   <= fwd_r ? pos_r + 1'b1 : pos_r - 1'b1;
          taken_r <= taken_r + 1'b1;
          if (remain_r <= CNT_W'(1)) begin
            remain_r <= '0;
            phase_r  <= PH_IDLE;
          end else begin
            remain_r <= remain_r - 1'b1;
            if (phase_r == PH_ACCEL) ramp_cnt_r <= ramp_cnt_r + 1'b1;
          end
        end
        OP_ACCEL_APPLY: begin
          if (root >= ROOT_W'(cruise_r)) begin
            cur_r   <= cruise_r;
            phase_r <= PH_CRUISE;
          end else begin
            cur_r <= root[RATE_W-1:0];
            if (past_dp) begin
              entry_r <= root[RATE_W-1:0];
              phase_r <= PH_DECEL;
            end
          end
        end
        OP_CRUISE_APPLY: if (past_dp) begin
          entry_r <= cur_r;
          phase_r <= PH_DECEL;
        end
        OP_DECEL_MIN:   cur_r <= min_r;
        OP_DECEL_APPLY: cur_r <= (dec_t < min_r) ? min_r : dec_t;
        default: ;
      endcase
    end
  end

  // item capture, result flags and scratch arithmetic
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r   <= in_mode;
        steps_r  <= in_data[31:0];
        newpos_r <= in_data[63:32];
        pulse_r  <= 1'b0; load_r <= 1'b0; acc_ok_r <= 1'b0;
        done_r   <= 1'b0; compl_r <= 1'b0; ivl_r <= '0;
      end
      OP_START_INIT: begin acc_ok_r <= 1'b1; load_r <= 1'b1; end
      OP_HALT:       done_r <= 1'b1;
      OP_TICK_BASE: begin
        pulse_r <= 1'b1;
        if (remain_r <= CNT_W'(1)) begin
          done_r  <= 1'b1;
          compl_r <= 1'b1;
        end else begin
          load_r <= 1'b1;
        end
      end
      OP_MUL_CRUISE, OP_MUL_CUR, OP_MUL_MIN, OP_MUL_ENTRY: acc_r <= SQ_W'(mul_p);
      OP_MUL_ACNT, OP_MUL_AN: prod_r <= mul_p;
      OP_SUM:  acc_r <= acc_r + prod2;
      OP_DIFF: acc_r <= acc_r - prod2;
      OP_SET_IVL: begin
        if (div_q == '0) ivl_r <= IVL_W'(1);
        else if (div_q > DIV_NW'(IVL_MAX)) ivl_r <= IVL_MAX;
        else ivl_r <= div_q[IVL_W-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= {5'b0, compl_r, done_r, acc_ok_r, (phase_r != PH_IDLE), load_r,
                  ivl_r, pos_r, fwd_r, pulse_r};
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign st.mode      = mode_r;
  assign st.phase     = phase_r;
  assign st.steps_nz  = steps_r != '0;
  assign st.stop_ramp = (phase_r != PH_DECEL) && (cur_r > min_r);
  assign st.tick_end  = done_r;
  assign st.red_ge    = prod2 >= acc_r;
  assign st.out_free  = ~ovalid_r | out_ready;
  assign st.div_done  = div_done;
  assign st.sqrt_done = sqrt_done;
endmodule

@@ rtl/core/stramp_ctrl.sv @@
// Controller: sequences datapath operations for each item.
module stramp_ctrl import stramp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);
  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_DISPATCH = 19'h00002,
    S_ST_MUL   = 19'h00004,
    S_ST_DIV   = 19'h00008,
    S_ST_DP    = 19'h00010,
    S_SP_MUL   = 19'h00020,
    S_SP_DIV   = 19'h00040,
    S_SP_APPLY = 19'h00080,
    S_TK_BASE  = 19'h00100,
    S_AC_MUL2  = 19'h00200,
    S_AC_SUM   = 19'h00400,
    S_AC_SQRT  = 19'h00800,
    S_AC_APPLY = 19'h01000,
    S_DC_MUL2  = 19'h02000,
    S_DC_DIFF  = 19'h04000,
    S_DC_SQRT  = 19'h08000,
    S_DC_APPLY = 19'h10000,
    S_IVL      = 19'h20000,
    S_OUT      = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    state_nxt    = state_r;
    launched_nxt = launched_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_OUT;
        case (st.mode)
          MODE_START: if (st.phase == PH_IDLE && st.steps_nz) begin
            cmd.op    = OP_START_INIT;
            state_nxt = S_ST_MUL;
          end
          MODE_STOP: if (st.phase != PH_IDLE) begin
            if (st.stop_ramp) state_nxt = S_SP_MUL;
            else cmd.op = OP_HALT;
          end
          MODE_SETPOS: cmd.op = OP_SETPOS;
          default: if (st.phase != PH_IDLE) begin
            cmd.op    = OP_TICK_BASE;
            state_nxt = S_TK_BASE;
          end
        endcase
      end
      S_ST_MUL: begin
        cmd.op    = OP_MUL_CRUISE;
        state_nxt = S_ST_DIV;
      end
      S_ST_DIV: if (!launched_r) begin
        cmd.div_start = 1'b1;
        launched_nxt  = 1'b1;
      end else if (st.div_done) begin
        launched_nxt = 1'b0;
        state_nxt    = S_ST_DP;
      end
      S_ST_DP: begin
        cmd.op    = OP_START_DP;
        state_nxt = S_IVL;
      end
      S_SP_MUL: begin
        cmd.op    = OP_MUL_CUR;
        state_nxt = S_SP_DIV;
      end
      S_SP_DIV: if (!launched_r) begin
        cmd.div_start = 1'b1;
        launched_nxt  = 1'b1;
      end else if (st.div_done) begin
        launched_nxt = 1'b0;
        state_nxt    = S_SP_APPLY;
      end
      S_SP_APPLY: begin
        cmd.op    = OP_STOP_APPLY;
        state_nxt = S_OUT;
      end
      S_TK_BASE: begin
        if (st.tick_end) begin
          state_nxt = S_OUT;
        end else begin
          case (st.phase)
            PH_ACCEL: begin
              cmd.op    = OP_MUL_MIN;
              state_nxt = S_AC_MUL2;
            end
            PH_CRUISE: begin
              cmd.op    = OP_CRUISE_APPLY;
              state_nxt = S_IVL;
            end
            default: begin
              cmd.op    = OP_MUL_ENTRY;
              state_nxt = S_DC_MUL2;
            end
          endcase
        end
      end
      S_AC_MUL2: begin
        cmd.op    = OP_MUL_ACNT;
        state_nxt = S_AC_SUM;
      end
      S_AC_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_AC_SQRT;
      end
      S_AC_SQRT: if (!launched_r) begin
        cmd.sqrt_start = 1'b1;
        launched_nxt   = 1'b1;
      end else if (st.sqrt_done) begin
        launched_nxt = 1'b0;
        state_nxt    = S_AC_APPLY;
      end
      S_AC_APPLY: begin
        cmd.op    = OP_ACCEL_APPLY;
        state_nxt = S_IVL;
      end
      S_DC_MUL2: begin
        cmd.op    = OP_MUL_AN;
        state_nxt = S_DC_DIFF;
      end
      S_DC_DIFF: begin
        if (st.red_ge) begin
          cmd.op    = OP_DECEL_MIN;
          state_nxt = S_IVL;
        end else begin
          cmd.op    = OP_DIFF;
          state_nxt = S_DC_SQRT;
        end
      end
      S_DC_SQRT: if (!launched_r) begin
        cmd.sqrt_start = 1'b1;
        launched_nxt   = 1'b1;
      end else if (st.sqrt_done) begin
        launched_nxt = 1'b0;
        state_nxt    = S_DC_APPLY;
      end
      S_DC_APPLY: begin
        cmd.op    = OP_DECEL_APPLY;
        state_nxt = S_IVL;
      end
      S_IVL: begin
        cmd.div_ivl = 1'b1;
        if (!launched_r) begin
          cmd.div_start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (st.div_done) begin
          cmd.op       = OP_SET_IVL;
          launched_nxt = 1'b0;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: if (st.out_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

@@ rtl/core/stramp_chk.sv @@
// Port-level checker for the step-rate generator, bound to the top level.
module stramp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[57] && out_tdata[55]))
    else $error("move reported done while still running");

  a_ivl_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[54] |-> out_tdata[53:34] != 20'd0)
    else $error("zero timer interval loaded");
endmodule

bind stepper_trapezoid_ramp_unit stramp_chk u_stramp_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
